FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the chunk header parser.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off while reset is held.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/rtmpchp_pkg.sv
// Types and constants of the RTMP chunk header parser.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package rtmpchp_pkg;

    typedef enum logic [1:0] {
        PH_BASIC = 2'd0,
        PH_CSID  = 2'd1,
        PH_MSG   = 2'd2,
        PH_EXT   = 2'd3
    } t_phase;

    localparam logic [1:0]  FMT_FULL       = 2'd0;
    localparam logic [1:0]  FMT_DELTA      = 2'd1;
    localparam logic [1:0]  FMT_DELTA_ONLY = 2'd2;
    localparam logic [1:0]  FMT_NONE       = 2'd3;

    localparam logic [5:0]  CSID_SHORT_MARK = 6'h00;
    localparam logic [5:0]  CSID_LONG_MARK  = 6'h3f;
    localparam logic [16:0] CSID_OFFSET     = 17'd64;
    localparam logic [23:0] TS_ESCAPE       = 24'hffffff;
    localparam logic [3:0]  EXT_BYTES       = 4'd4;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_TRUNC = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_buffer;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  fmt;
        logic [16:0] chunk_stream_id;
        logic [31:0] timestamp;
        logic [23:0] timestamp_delta;
        logic [23:0] message_length;
        logic [7:0]  message_type;
        logic [31:0] message_stream_id;
        logic [31:0] extended_timestamp;
        logic        extended_present;
        logic [4:0]  header_bytes;
        logic        status;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

    function automatic logic [3:0] msg_len(input logic [1:0] fmt);
        logic [3:0] len;
        case (fmt)
            FMT_FULL:       len = 4'd11;
            FMT_DELTA:      len = 4'd7;
            FMT_DELTA_ONLY: len = 4'd3;
            default:        len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: hw/rtl/rtmpchp_if.sv
// Request channels of the chunk header parser: input bytes and header results.
// Depends on nothing.
`timescale 1ns / 1ps

interface rtmpchp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in_buffer;

    modport source (output valid, output data_byte, output last_in_buffer, input ready);
    modport sink   (input valid, input data_byte, input last_in_buffer, output ready);
endinterface

interface rtmpchp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  fmt;
    logic [16:0] chunk_stream_id;
    logic [31:0] timestamp;
    logic [23:0] timestamp_delta;
    logic [23:0] message_length;
    logic [7:0]  message_type;
    logic [31:0] message_stream_id;
    logic [31:0] extended_timestamp;
    logic        extended_present;
    logic [4:0]  header_bytes;
    logic        status;

    modport source (
        output valid, input ready,
        output fmt, output chunk_stream_id, output timestamp, output timestamp_delta,
        output message_length, output message_type, output message_stream_id,
        output extended_timestamp, output extended_present, output header_bytes,
        output status
    );
    modport sink (
        input valid, output ready,
        input fmt, input chunk_stream_id, input timestamp, input timestamp_delta,
        input message_length, input message_type, input message_stream_id,
        input extended_timestamp, input extended_present, input header_bytes,
        input status
    );
endinterface

FILE: hw/rtl/rtmpchp_parser.sv
// Byte-serial header decode: phase state, field shift registers and previous header.
// Depends on rtmpchp_pkg; produces at most one result per accepted byte.
`timescale 1ns / 1ps

module rtmpchp_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  rtmpchp_pkg::t_in_item i_item,
    output rtmpchp_pkg::t_result  o_result
);

    rtmpchp_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_bip, n_bip;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_skip, n_skip;
    logic        r_long, n_long;
    logic [1:0]  r_fmt, n_fmt;
    logic [16:0] r_csid, n_csid;
    logic [31:0] r_ext, n_ext;
    logic [23:0] r_ts_raw, n_ts_raw;
    logic [23:0] r_delta, n_delta;
    logic [23:0] r_len, n_len;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_sid, n_sid;
    logic [31:0] r_prev_ts, n_prev_ts;
    logic [23:0] r_prev_delta, n_prev_delta;
    logic [23:0] r_prev_len, n_prev_len;
    logic [7:0]  r_prev_type, n_prev_type;
    logic [31:0] r_prev_sid, n_prev_sid;

    logic [7:0]  w_b;
    logic        w_last;
    logic        w_after_csid;
    logic        w_after_msg;
    logic        w_fin;
    logic        w_fin_ext;
    logic        w_need_ext;
    logic [23:0] w_addend;
    logic [31:0] w_ts_sum;
    rtmpchp_pkg::t_out_item w_fin_item;
    rtmpchp_pkg::t_result   w_result;

    assign w_b    = i_item.data_byte;
    assign w_last = i_item.last_in_buffer;

    always_comb begin
        n_phase = r_phase;
        n_bip   = r_bip;
        n_cnt   = r_cnt;
        n_skip  = r_skip;
        n_long  = r_long;
        n_fmt   = r_fmt;
        n_csid  = r_csid;
        n_ext   = r_ext;
        n_ts_raw = r_ts_raw;
        n_delta = r_delta;
        n_len   = r_len;
        n_type  = r_type;
        n_sid   = r_sid;
        w_after_csid = 1'b0;
        w_after_msg  = 1'b0;
        w_fin        = 1'b0;
        w_fin_ext    = 1'b0;
        w_need_ext   = 1'b0;
        if (!r_skip) begin
            unique case (r_phase)
                rtmpchp_pkg::PH_CSID: begin
                    n_cnt = r_cnt + 5'd1;
                    n_bip = r_bip + 4'd1;
                    if (!r_long) begin
                        n_csid = {9'd0, w_b} + rtmpchp_pkg::CSID_OFFSET;
                        w_after_csid = 1'b1;
                    end else if (r_bip == 4'd0) begin
                        n_csid = {9'd0, w_b};
                    end else begin
                        n_csid = {1'b0, w_b, 8'd0} + r_csid + rtmpchp_pkg::CSID_OFFSET;
                        w_after_csid = 1'b1;
                    end
                end
                rtmpchp_pkg::PH_MSG: begin
                    n_cnt = r_cnt + 5'd1;
                    n_bip = r_bip + 4'd1;
                    if (r_bip < 4'd3) begin
                        if (r_fmt == rtmpchp_pkg::FMT_FULL) begin
                            n_ts_raw = {r_ts_raw[15:0], w_b};
                        end else begin
                            n_delta = {r_delta[15:0], w_b};
                        end
                    end else if (r_bip < 4'd6) begin
                        n_len = {r_len[15:0], w_b};
                    end else if (r_bip == 4'd6) begin
                        n_type = w_b;
                    end else begin
                        n_sid = {r_sid[23:0], w_b};
                    end
                    if (n_bip >= rtmpchp_pkg::msg_len(r_fmt)) begin
                        w_after_msg = 1'b1;
                    end
                end
                rtmpchp_pkg::PH_EXT: begin
                    n_cnt = r_cnt + 5'd1;
                    n_bip = r_bip + 4'd1;
                    n_ext = {r_ext[23:0], w_b};
                    if (n_bip >= rtmpchp_pkg::EXT_BYTES) begin
                        w_fin     = 1'b1;
                        w_fin_ext = 1'b1;
                    end
                end
                default: begin
                    n_fmt    = w_b[7:6];
                    n_csid   = '0;
                    n_ext    = '0;
                    n_ts_raw = '0;
                    n_delta  = '0;
                    n_len    = '0;
                    n_type   = '0;
                    n_sid    = '0;
                    n_cnt    = 5'd1;
                    n_bip    = 4'd0;
                    n_long   = (w_b[5:0] == rtmpchp_pkg::CSID_LONG_MARK);
                    if (w_b[5:0] == rtmpchp_pkg::CSID_SHORT_MARK ||
                        w_b[5:0] == rtmpchp_pkg::CSID_LONG_MARK) begin
                        n_phase = rtmpchp_pkg::PH_CSID;
                    end else begin
                        n_csid = {11'd0, w_b[5:0]};
                        w_after_csid = 1'b1;
                    end
                end
            endcase

            if (w_after_csid) begin
                if (rtmpchp_pkg::msg_len(n_fmt) == 4'd0) begin
                    w_after_msg = 1'b1;
                end else begin
                    n_phase = rtmpchp_pkg::PH_MSG;
                    n_bip   = 4'd0;
                end
            end

            w_need_ext =
                (n_fmt == rtmpchp_pkg::FMT_FULL && n_ts_raw == rtmpchp_pkg::TS_ESCAPE) ||
                ((n_fmt == rtmpchp_pkg::FMT_DELTA || n_fmt == rtmpchp_pkg::FMT_DELTA_ONLY) &&
                 n_delta == rtmpchp_pkg::TS_ESCAPE);

            if (w_after_msg) begin
                if (w_need_ext) begin
                    n_phase = rtmpchp_pkg::PH_EXT;
                    n_bip   = 4'd0;
                    n_ext   = '0;
                end else begin
                    w_fin = 1'b1;
                end
            end

            if (w_fin || w_last) begin
                n_phase = rtmpchp_pkg::PH_BASIC;
                n_bip   = 4'd0;
                n_skip  = w_fin && !w_last;
            end
        end else if (w_last) begin
            n_skip  = 1'b0;
            n_phase = rtmpchp_pkg::PH_BASIC;
            n_bip   = 4'd0;
        end
    end

    assign w_addend = (n_fmt == rtmpchp_pkg::FMT_NONE) ? r_prev_delta : n_delta;
    assign w_ts_sum = r_prev_ts + {8'd0, w_addend};

    always_comb begin
        w_fin_item = '0;
        w_fin_item.fmt                = n_fmt;
        w_fin_item.chunk_stream_id    = n_csid;
        w_fin_item.extended_timestamp = w_fin_ext ? n_ext : 32'd0;
        w_fin_item.extended_present   = w_fin_ext;
        w_fin_item.header_bytes       = n_cnt;
        w_fin_item.status             = rtmpchp_pkg::STATUS_DONE;
        w_fin_item.timestamp          = w_ts_sum;
        w_fin_item.timestamp_delta    = w_addend;
        w_fin_item.message_length     = r_prev_len;
        w_fin_item.message_type       = r_prev_type;
        w_fin_item.message_stream_id  = r_prev_sid;
        case (n_fmt)
            rtmpchp_pkg::FMT_FULL: begin
                w_fin_item.timestamp         = {8'd0, n_ts_raw};
                w_fin_item.timestamp_delta   = 24'd0;
                w_fin_item.message_length    = n_len;
                w_fin_item.message_type      = n_type;
                w_fin_item.message_stream_id = n_sid;
            end
            rtmpchp_pkg::FMT_DELTA: begin
                w_fin_item.message_length = n_len;
                w_fin_item.message_type   = n_type;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_result = '0;
        n_prev_ts    = r_prev_ts;
        n_prev_delta = r_prev_delta;
        n_prev_len   = r_prev_len;
        n_prev_type  = r_prev_type;
        n_prev_sid   = r_prev_sid;
        if (i_accept && !r_skip) begin
            if (w_fin) begin
                w_result.valid = 1'b1;
                w_result.item  = w_fin_item;
                n_prev_ts    = w_fin_item.timestamp;
                n_prev_delta = w_fin_item.timestamp_delta;
                n_prev_len   = w_fin_item.message_length;
                n_prev_type  = w_fin_item.message_type;
                n_prev_sid   = w_fin_item.message_stream_id;
            end else if (w_last) begin
                w_result.valid             = 1'b1;
                w_result.item.fmt          = n_fmt;
                w_result.item.header_bytes = n_cnt;
                w_result.item.status       = rtmpchp_pkg::STATUS_TRUNC;
            end
        end
    end

    assign o_result = w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= rtmpchp_pkg::PH_BASIC;
            r_bip        <= '0;
            r_cnt        <= '0;
            r_skip       <= 1'b0;
            r_long       <= 1'b0;
            r_fmt        <= '0;
            r_csid       <= '0;
            r_ext        <= '0;
            r_ts_raw     <= '0;
            r_delta      <= '0;
            r_len        <= '0;
            r_type       <= '0;
            r_sid        <= '0;
            r_prev_ts    <= '0;
            r_prev_delta <= '0;
            r_prev_len   <= '0;
            r_prev_type  <= '0;
            r_prev_sid   <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bip        <= n_bip;
            r_cnt        <= n_cnt;
            r_skip       <= n_skip;
            r_long       <= n_long;
            r_fmt        <= n_fmt;
            r_csid       <= n_csid;
            r_ext        <= n_ext;
            r_ts_raw     <= n_ts_raw;
            r_delta      <= n_delta;
            r_len        <= n_len;
            r_type       <= n_type;
            r_sid        <= n_sid;
            r_prev_ts    <= n_prev_ts;
            r_prev_delta <= n_prev_delta;
            r_prev_len   <= n_prev_len;
            r_prev_type  <= n_prev_type;
            r_prev_sid   <= n_prev_sid;
        end
    end

endmodule

FILE: hw/rtl/rtmpchp_out_buf.sv
// Result register with a skid stage for the header result channel.
// Depends on rtmpchp_pkg.
`timescale 1ns / 1ps

module rtmpchp_out_buf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rtmpchp_pkg::t_result   i_result,
    output logic                   o_in_ready,
    output logic                   o_valid,
    output rtmpchp_pkg::t_out_item o_item,
    input  logic                   i_ready
);

    logic                   r_main_valid, n_main_valid;
    logic                   r_skid_valid, n_skid_valid;
    rtmpchp_pkg::t_out_item r_main, n_main;
    rtmpchp_pkg::t_out_item r_skid, n_skid;
    logic                   w_pop;

    assign w_pop = r_main_valid && i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (!r_main_valid || w_pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_result.item;
                n_main_valid = i_result.valid;
            end
        end else if (i_result.valid) begin
            n_skid       = i_result.item;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_item     = r_main;

endmodule

FILE: hw/rtl/rtmp_chunk_header_parser.sv
// Top level of the RTMP chunk header parser.
// Depends on rtmpchp_pkg, rtmpchp_if, rtmpchp_parser and rtmpchp_out_buf.
`timescale 1ns / 1ps

// Usage
//   i_in  : one request per byte of a received buffer; last_in_buffer marks the
//           final byte. The first byte of every buffer is a basic header.
//   o_out : one request per chunk header, either a complete header with omitted
//           fields filled from the previous header, or status 1 when the buffer
//           ended before the header was complete. Payload bytes give nothing.
//   Throughput: one byte per cycle while i_in.ready is high. A byte is decoded and the
//           phase, field and previous-header registers are updated as it is taken.
//   Result path: the result of the byte that ends the header (or the buffer) is
//           registered in the result register, or in its skid stage while o_out stalls.
//   Stall: the result register has a skid stage behind it; i_in.ready drops only
//           while two results wait, and rises the cycle after o_out takes one.
//   Reset: synchronous, active low. The parser expects a basic header, the
//           previous header reads as all zero and both result slots are empty.

module rtmp_chunk_header_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rtmpchp_in_if.sink     i_in,
    rtmpchp_out_if.source  o_out
);

    logic                   w_accept;
    logic                   w_in_ready;
    logic                   w_out_valid;
    rtmpchp_pkg::t_in_item  w_in_item;
    rtmpchp_pkg::t_result   w_result;
    rtmpchp_pkg::t_out_item w_out_item;

    assign i_in.ready = w_in_ready;
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_in_item.data_byte      = i_in.data_byte;
    assign w_in_item.last_in_buffer = i_in.last_in_buffer;

    rtmpchp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (w_in_item),
        .o_result (w_result)
    );

    rtmpchp_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (w_result),
        .o_in_ready (w_in_ready),
        .o_valid    (w_out_valid),
        .o_item     (w_out_item),
        .i_ready    (o_out.ready)
    );

    assign o_out.valid              = w_out_valid;
    assign o_out.fmt                = w_out_item.fmt;
    assign o_out.chunk_stream_id    = w_out_item.chunk_stream_id;
    assign o_out.timestamp          = w_out_item.timestamp;
    assign o_out.timestamp_delta    = w_out_item.timestamp_delta;
    assign o_out.message_length     = w_out_item.message_length;
    assign o_out.message_type       = w_out_item.message_type;
    assign o_out.message_stream_id  = w_out_item.message_stream_id;
    assign o_out.extended_timestamp = w_out_item.extended_timestamp;
    assign o_out.extended_present   = w_out_item.extended_present;
    assign o_out.header_bytes       = w_out_item.header_bytes;
    assign o_out.status             = w_out_item.status;

endmodule

FILE: hw/rtl/rtmpchp_checker.sv
// Port-level checks of the chunk header parser, bound to the top level.
// Depends on assert_macros.svh and rtmpchp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtmpchp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_fmt,
    input logic [16:0] i_chunk_stream_id,
    input logic [31:0] i_timestamp,
    input logic [23:0] i_timestamp_delta,
    input logic [23:0] i_message_length,
    input logic [7:0]  i_message_type,
    input logic [31:0] i_message_stream_id,
    input logic [31:0] i_extended_timestamp,
    input logic        i_extended_present,
    input logic [4:0]  i_header_bytes,
    input logic        i_status
);

    logic [177:0] w_out_word;
    logic         w_trunc_clean;
    logic         w_done_sane;

    assign w_out_word = {i_fmt, i_chunk_stream_id, i_timestamp, i_timestamp_delta,
                         i_message_length, i_message_type, i_message_stream_id,
                         i_extended_timestamp, i_extended_present, i_header_bytes,
                         i_status};

    assign w_trunc_clean = i_chunk_stream_id == 17'd0 && i_timestamp == 32'd0 &&
                           i_timestamp_delta == 24'd0 && i_message_length == 24'd0 &&
                           i_message_type == 8'd0 && i_message_stream_id == 32'd0 &&
                           i_extended_timestamp == 32'd0 && !i_extended_present;

    assign w_done_sane = i_header_bytes != 5'd0 && i_header_bytes <= 5'd18 &&
                         (i_extended_present || i_extended_timestamp == 32'd0) &&
                         (i_fmt != rtmpchp_pkg::FMT_FULL || i_timestamp_delta == 24'd0) &&
                         (i_fmt != rtmpchp_pkg::FMT_NONE || !i_extended_present);

    `CHK_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result after reset")
    `CHK_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(w_out_word), "stalled result changed")
    `CHK_ASSERT(a_trunc_clean, i_clk, i_rst_n, i_out_valid && i_status == rtmpchp_pkg::STATUS_TRUNC |-> w_trunc_clean, "truncated result carries fields")
    `CHK_ASSERT(a_done_sane, i_clk, i_rst_n, i_out_valid && i_status == rtmpchp_pkg::STATUS_DONE |-> w_done_sane, "inconsistent complete header")

endmodule

bind rtmp_chunk_header_parser rtmpchp_checker u_rtmpchp_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_fmt                (o_out.fmt),
    .i_chunk_stream_id    (o_out.chunk_stream_id),
    .i_timestamp          (o_out.timestamp),
    .i_timestamp_delta    (o_out.timestamp_delta),
    .i_message_length     (o_out.message_length),
    .i_message_type       (o_out.message_type),
    .i_message_stream_id  (o_out.message_stream_id),
    .i_extended_timestamp (o_out.extended_timestamp),
    .i_extended_present   (o_out.extended_present),
    .i_header_bytes       (o_out.header_bytes),
    .i_status             (o_out.status)
);
